[design/mtep_pkg.sv]
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types, codes and constants of the MIDI track event parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtep_pkg;

    // default width of variable-length accumulators
    localparam int VLQ_BITS_DEF = 28;

    // fixed field widths
    localparam int DELTA_W = 28;
    localparam int TEMPO_W = 24;

    // status and meta codes
    localparam logic [7:0] ST_SYSEX   = 8'hF0;
    localparam logic [7:0] ST_ESCAPE  = 8'hF7;
    localparam logic [7:0] ST_META    = 8'hFF;
    localparam logic [7:0] ST_CHN_MIN = 8'h80;
    localparam logic [7:0] ST_CHN_MAX = 8'hEF;
    localparam logic [7:0] META_NAME  = 8'h04;
    localparam logic [7:0] META_TEMPO = 8'h51;
    localparam logic [7:0] META_EOT   = 8'h2F;

    // high nibbles and top bits of channel statuses
    localparam logic [3:0] HI_NOTE_ON = 4'h9;
    localparam logic [3:0] HI_PROGRAM = 4'hC;
    localparam logic [3:0] HI_PRESS   = 4'hD;
    localparam logic [2:0] TOP_NOTE   = 3'b100;

    // event kinds
    localparam logic [2:0] KIND_OTHER = 3'd0;
    localparam logic [2:0] KIND_OFF   = 3'd1;
    localparam logic [2:0] KIND_ON    = 3'd2;
    localparam logic [2:0] KIND_NAME  = 3'd3;
    localparam logic [2:0] KIND_TEMPO = 3'd4;
    localparam logic [2:0] KIND_EOT   = 3'd5;

    // parser phases
    typedef enum logic [3:0] {
        PH_DELTA,
        PH_STATUS,
        PH_NOTE,
        PH_VEL,
        PH_SKIP,
        PH_SKIP_LEN,
        PH_META,
        PH_NAME_LEN,
        PH_NAME,
        PH_TEMPO_LEN,
        PH_TEMPO,
        PH_EOT_LEN
    } t_phase;

    // one decoded result
    typedef struct packed {
        logic [2:0]         event_kind;
        logic [DELTA_W-1:0] delta_time;
        logic [7:0]         status_value;
        logic [6:0]         note_key;
        logic [6:0]         note_velocity;
        logic [TEMPO_W-1:0] tempo_value;
        logic [7:0]         name_char;
        logic               char_valid;
        logic               last;
    } t_result;

endpackage

[design/mtep_in_if.sv]
// ----------------------------------------------------------------------------
// mtep_in_if
// Byte request channel into the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mtep_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       track_start;

    modport source (output valid, output data_byte, output track_start, input ready);
    modport sink   (input valid, input data_byte, input track_start, output ready);
endinterface

[design/mtep_out_if.sv]
// ----------------------------------------------------------------------------
// mtep_out_if
// Event request channel out of the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mtep_out_if;
    import mtep_pkg::*;

    logic               valid;
    logic               ready;
    logic [2:0]         event_kind;
    logic [DELTA_W-1:0] delta_time;
    logic [7:0]         status_value;
    logic [6:0]         note_key;
    logic [6:0]         note_velocity;
    logic [TEMPO_W-1:0] tempo_value;
    logic [7:0]         name_char;
    logic               char_valid;
    logic               last;

    modport source (
        output valid, output event_kind, output delta_time, output status_value,
        output note_key, output note_velocity, output tempo_value,
        output name_char, output char_valid, output last, input ready
    );
    modport sink (
        input valid, input event_kind, input delta_time, input status_value,
        input note_key, input note_velocity, input tempo_value,
        input name_char, input char_valid, input last, output ready
    );
endinterface

[design/midi_track_event_parser.sv]
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Each result is registered in the result buffer when the byte that completes its event is accepted.
// Throughput: one byte per cycle while ready is high, set by the single decode step in mtep_core.
// Output stalls are absorbed by a two-entry result buffer; ready drops only
// when both entries hold requests. Synchronous active-low reset returns the
// parser to delta-time phase with running status cleared and no pending events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module midi_track_event_parser #(
    parameter int VLQ_BITS = mtep_pkg::VLQ_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mtep_in_if.sink    i_in,
    mtep_out_if.source o_out
);
    import mtep_pkg::*;

    logic    w_accept;
    logic    w_push;
    logic    w_ready;
    t_result w_result;

    // byte request handshake
    assign i_in.ready = w_ready;
    assign w_accept   = i_in.valid && w_ready;

    // decode
    mtep_core #(
        .VLQ_BITS (VLQ_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_data_byte   (i_in.data_byte),
        .i_track_start (i_in.track_start),
        .o_push        (w_push),
        .o_result      (w_result)
    );

    // result buffer
    mtep_skid u_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_result (w_result),
        .o_ready  (w_ready),
        .o_out    (o_out)
    );

    // input stalls only with a full buffer, which shows a result
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid)
        else $error("input stalled with empty result register");

    // a full, stalled buffer stays full
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_in.ready && !o_out.ready) |=> !i_in.ready)
        else $error("skid entry lost under stall");

    // only name characters may continue an event
    a_last_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.last) |-> (o_out.event_kind == KIND_NAME))
        else $error("non-final result of a kind other than name");

    // kind codes stay within the defined set
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.event_kind <= KIND_EOT))
        else $error("undefined event kind");

endmodule

[design/mtep_core.sv]
// ----------------------------------------------------------------------------
// mtep_core
// Parser state and the one-step decode of each accepted byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtep_core #(
    parameter int VLQ_BITS = mtep_pkg::VLQ_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    input  logic             i_track_start,
    output logic             o_push,
    output mtep_pkg::t_result o_result
);
    import mtep_pkg::*;

    // parser state
    t_phase              r_phase,  n_phase,  c_phase;
    logic [7:0]          r_run,    n_run,    c_run;
    logic [7:0]          r_cur,    n_cur,    c_cur;
    logic [VLQ_BITS-1:0] r_delta,  n_delta,  c_delta;
    logic [VLQ_BITS-1:0] r_len,    n_len,    c_len;
    logic [VLQ_BITS-1:0] r_rem,    n_rem,    c_rem;
    logic [6:0]          r_held,   n_held,   c_held;
    logic [TEMPO_W-1:0]  r_tempo,  n_tempo,  c_tempo;

    logic                w_more;
    logic [VLQ_BITS-1:0] w_delta_sum;
    logic [VLQ_BITS-1:0] w_len_sum;
    logic [VLQ_BITS-1:0] w_rem_dec;
    logic [TEMPO_W-1:0]  w_tempo_sum;
    logic [DELTA_W-1:0]  w_delta_out;
    logic                w_byte_chn,  w_byte_note;
    logic                w_run_chn,   w_run_note,  w_run_one;
    logic                w_byte_one;
    logic                s_emit, s_last;

    // track start clears everything before this byte is handled
    always_comb begin
        c_phase = i_track_start ? PH_DELTA : r_phase;
        c_run   = i_track_start ? '0 : r_run;
        c_cur   = i_track_start ? '0 : r_cur;
        c_delta = i_track_start ? '0 : r_delta;
        c_len   = i_track_start ? '0 : r_len;
        c_rem   = i_track_start ? '0 : r_rem;
        c_held  = i_track_start ? '0 : r_held;
        c_tempo = i_track_start ? '0 : r_tempo;
    end

    // shared datapath terms
    assign w_more      = i_data_byte[7];
    assign w_delta_sum = {c_delta[VLQ_BITS-8:0], i_data_byte[6:0]};
    assign w_len_sum   = {c_len[VLQ_BITS-8:0], i_data_byte[6:0]};
    assign w_rem_dec   = (c_rem != '0) ? c_rem - VLQ_BITS'(1) : c_rem;
    assign w_tempo_sum = {c_tempo[TEMPO_W-9:0], i_data_byte};

    // status classification
    assign w_byte_chn  = (i_data_byte >= ST_CHN_MIN) && (i_data_byte <= ST_CHN_MAX);
    assign w_byte_note = (i_data_byte[7:5] == TOP_NOTE);
    assign w_byte_one  = (i_data_byte[7:4] == HI_PROGRAM) || (i_data_byte[7:4] == HI_PRESS);
    assign w_run_chn   = (c_run >= ST_CHN_MIN) && (c_run <= ST_CHN_MAX);
    assign w_run_note  = (c_run[7:5] == TOP_NOTE);
    assign w_run_one   = (c_run[7:4] == HI_PROGRAM) || (c_run[7:4] == HI_PRESS);

    // delta time fits the fixed output width
    generate
        if (VLQ_BITS >= DELTA_W) begin : g_delta_cut
            assign w_delta_out = c_delta[DELTA_W-1:0];
        end else begin : g_delta_ext
            assign w_delta_out = {{(DELTA_W-VLQ_BITS){1'b0}}, c_delta};
        end
    endgenerate

    // next phase
    always_comb begin
        n_phase = c_phase;
        unique case (c_phase)
            PH_DELTA: begin
                if (!w_more) n_phase = PH_STATUS;
            end
            PH_STATUS: begin
                if (!w_more) begin
                    if (w_run_chn && w_run_note) n_phase = PH_VEL;
                    else if (w_run_chn && !w_run_one) n_phase = PH_SKIP;
                end else if (w_byte_chn) begin
                    n_phase = w_byte_note ? PH_NOTE : PH_SKIP;
                end else if (i_data_byte == ST_SYSEX || i_data_byte == ST_ESCAPE) begin
                    n_phase = PH_SKIP_LEN;
                end else if (i_data_byte == ST_META) begin
                    n_phase = PH_META;
                end
            end
            PH_NOTE:      n_phase = PH_VEL;
            PH_VEL:       n_phase = PH_VEL;
            PH_SKIP:      n_phase = PH_SKIP;
            PH_SKIP_LEN: begin
                if (!w_more && w_len_sum != '0) n_phase = PH_SKIP;
            end
            PH_META: begin
                case (i_data_byte)
                    META_NAME:  n_phase = PH_NAME_LEN;
                    META_TEMPO: n_phase = PH_TEMPO_LEN;
                    META_EOT:   n_phase = PH_EOT_LEN;
                    default:    n_phase = PH_SKIP_LEN;
                endcase
            end
            PH_NAME_LEN: begin
                if (!w_more && w_len_sum != '0) n_phase = PH_NAME;
            end
            PH_NAME:      n_phase = PH_NAME;
            PH_TEMPO_LEN: n_phase = PH_TEMPO;
            PH_TEMPO:     n_phase = PH_TEMPO;
            PH_EOT_LEN:   n_phase = PH_EOT_LEN;
            default:      n_phase = PH_DELTA;
        endcase
        // a finished event returns to delta time
        if (s_emit && s_last) n_phase = PH_DELTA;
    end

    // data updates and result fields
    always_comb begin
        n_run   = c_run;
        n_cur   = c_cur;
        n_delta = c_delta;
        n_len   = c_len;
        n_rem   = c_rem;
        n_held  = c_held;
        n_tempo = c_tempo;
        s_emit  = 1'b0;
        s_last  = 1'b1;
        o_result              = '0;
        o_result.event_kind   = KIND_OTHER;
        unique case (c_phase)
            PH_DELTA: n_delta = w_delta_sum;
            PH_STATUS: begin
                n_held = '0;
                if (!w_more) begin
                    // running status
                    n_cur = c_run;
                    if (!w_run_chn) s_emit = 1'b1;
                    else if (w_run_note) n_held = i_data_byte[6:0];
                    else if (w_run_one) s_emit = 1'b1;
                    else n_rem = VLQ_BITS'(1);
                end else begin
                    n_cur = i_data_byte;
                    if (w_byte_chn) begin
                        n_run = i_data_byte;
                        if (!w_byte_note) n_rem = w_byte_one ? VLQ_BITS'(1) : VLQ_BITS'(2);
                    end else if (i_data_byte == ST_SYSEX || i_data_byte == ST_ESCAPE) begin
                        n_len = '0;
                    end else if (i_data_byte != ST_META) begin
                        s_emit = 1'b1;
                    end
                end
            end
            PH_NOTE: n_held = i_data_byte[6:0];
            PH_VEL: begin
                s_emit = 1'b1;
                o_result.event_kind    = (c_cur[7:4] == HI_NOTE_ON) ? KIND_ON : KIND_OFF;
                o_result.note_key      = c_held;
                o_result.note_velocity = i_data_byte[6:0];
            end
            PH_SKIP: begin
                n_rem = w_rem_dec;
                if (w_rem_dec == '0) s_emit = 1'b1;
            end
            PH_SKIP_LEN: begin
                n_len = w_len_sum;
                if (!w_more) begin
                    if (w_len_sum == '0) s_emit = 1'b1;
                    else n_rem = w_len_sum;
                end
            end
            PH_META: n_len = '0;
            PH_NAME_LEN: begin
                n_len = w_len_sum;
                if (!w_more) begin
                    if (w_len_sum == '0) begin
                        s_emit = 1'b1;
                        o_result.event_kind = KIND_NAME;
                    end else begin
                        n_rem = w_len_sum;
                    end
                end
            end
            PH_NAME: begin
                n_rem  = w_rem_dec;
                s_emit = 1'b1;
                s_last = (w_rem_dec == '0);
                o_result.event_kind = KIND_NAME;
                o_result.name_char  = i_data_byte;
                o_result.char_valid = 1'b1;
            end
            PH_TEMPO_LEN: begin
                n_tempo = '0;
                n_rem   = VLQ_BITS'(3);
            end
            PH_TEMPO: begin
                n_tempo = w_tempo_sum;
                n_rem   = w_rem_dec;
                if (w_rem_dec == '0) begin
                    s_emit = 1'b1;
                    o_result.event_kind  = KIND_TEMPO;
                    o_result.tempo_value = w_tempo_sum;
                end
            end
            PH_EOT_LEN: begin
                s_emit = 1'b1;
                o_result.event_kind = KIND_EOT;
            end
            default: n_delta = '0;
        endcase
        if (s_emit && s_last) n_delta = '0;
        o_result.delta_time   = w_delta_out;
        o_result.status_value = n_cur;
        o_result.last         = s_last;
    end

    assign o_push = i_accept && s_emit;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DELTA;
            r_run   <= '0;
            r_cur   <= '0;
            r_delta <= '0;
            r_len   <= '0;
            r_rem   <= '0;
            r_held  <= '0;
            r_tempo <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_run   <= n_run;
            r_cur   <= n_cur;
            r_delta <= n_delta;
            r_len   <= n_len;
            r_rem   <= n_rem;
            r_held  <= n_held;
            r_tempo <= n_tempo;
        end
    end

endmodule

[design/mtep_skid.sv]
// ----------------------------------------------------------------------------
// mtep_skid
// Result register with a skid entry, so input keeps flowing under a stall until the skid entry fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtep_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mtep_pkg::t_result i_result,
    output logic              o_ready,
    mtep_out_if.source        o_out
);
    import mtep_pkg::*;

    logic    r_main_v, n_main_v;
    logic    r_skid_v, n_skid_v;
    t_result r_main,   n_main;
    t_result r_skid,   n_skid;
    logic    w_pop;

    assign w_pop   = r_main_v && o_out.ready;
    assign o_ready = !r_skid_v;

    // fill and drain of the two entries
    always_comb begin
        n_main_v = r_main_v;
        n_skid_v = r_skid_v;
        n_main   = r_main;
        n_skid   = r_skid;
        if (r_skid_v) begin
            if (w_pop) begin
                n_main   = r_skid;
                n_skid_v = 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_v || w_pop) begin
                n_main   = i_result;
                n_main_v = 1'b1;
            end else begin
                n_skid   = i_result;
                n_skid_v = 1'b1;
            end
        end else if (w_pop) begin
            n_main_v = 1'b0;
        end
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_main_v <= n_main_v;
            r_skid_v <= n_skid_v;
        end
    end

    // payload entries
    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    // drive the output request
    assign o_out.valid         = r_main_v;
    assign o_out.event_kind    = r_main.event_kind;
    assign o_out.delta_time    = r_main.delta_time;
    assign o_out.status_value  = r_main.status_value;
    assign o_out.note_key      = r_main.note_key;
    assign o_out.note_velocity = r_main.note_velocity;
    assign o_out.tempo_value   = r_main.tempo_value;
    assign o_out.name_char     = r_main.name_char;
    assign o_out.char_valid    = r_main.char_valid;
    assign o_out.last          = r_main.last;

endmodule
